// ===== sv/vcsl_pkg.sv =====
// ----------------------------------------------------------------------------
// vcsl_pkg: shared types and constants for the voxel chunk slot lookup
// Slot geometry, key layout, configuration register codes and the structs
// that travel between the address split and the slot tag store.
// ----------------------------------------------------------------------------
package vcsl_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
	localparam int INDEX_BITS = 21;
	localparam int KEY_W      = 3 * INDEX_BITS;

	localparam int COORD_W    = 22;
	localparam int DIM_W      = 21;
	localparam int SHIFT_W    = 4;
	localparam int OFFSET_W   = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	// Largest chunk shift per axis; larger register values saturate here
	localparam logic [SHIFT_W-1:0] MAX_SHIFT = 4'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VOLUME_DEPTH  = 3'd0,
		REG_VOLUME_HEIGHT = 3'd1,
		REG_VOLUME_WIDTH  = 3'd2,
		REG_CHUNK_SHIFT_Z = 3'd3,
		REG_CHUNK_SHIFT_Y = 3'd4,
		REG_CHUNK_SHIFT_X = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [DIM_W-1:0]   volume_depth;
		logic [DIM_W-1:0]   volume_height;
		logic [DIM_W-1:0]   volume_width;
		logic [SHIFT_W-1:0] chunk_shift_z;
		logic [SHIFT_W-1:0] chunk_shift_y;
		logic [SHIFT_W-1:0] chunk_shift_x;
	} cfg_t;

	typedef struct packed {
		logic                out_of_range;
		logic [DIM_W-1:0]    chunk_z;
		logic [DIM_W-1:0]    chunk_y;
		logic [DIM_W-1:0]    chunk_x;
		logic [OFFSET_W-1:0] offset;
	} split_t;

	typedef struct packed {
		logic                 hit;
		logic [SLOT_BITS-1:0] slot;
	} lookup_t;

endpackage

// ===== sv/vcsl_if.sv =====
// ----------------------------------------------------------------------------
// vcsl_if: coordinate and result channels
// Valid/ready channels; a beat moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface vcsl_coord_if
	import vcsl_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] coord_z;
	logic signed [COORD_W-1:0] coord_y;
	logic signed [COORD_W-1:0] coord_x;

	modport source (output valid, output coord_z, output coord_y, output coord_x,
		input ready);
	modport sink (input valid, input coord_z, input coord_y, input coord_x,
		output ready);
endinterface

interface vcsl_result_if
	import vcsl_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic                 out_of_range;
	logic                 hit;
	logic [SLOT_BITS-1:0] slot_index;
	logic [DIM_W-1:0]     fetch_chunk_z;
	logic [DIM_W-1:0]     fetch_chunk_y;
	logic [DIM_W-1:0]     fetch_chunk_x;
	logic [OFFSET_W-1:0]  offset_in_chunk;

	modport source (output valid, output out_of_range, output hit, output slot_index,
		output fetch_chunk_z, output fetch_chunk_y, output fetch_chunk_x,
		output offset_in_chunk, input ready);
	modport sink (input valid, input out_of_range, input hit, input slot_index,
		input fetch_chunk_z, input fetch_chunk_y, input fetch_chunk_x,
		input offset_in_chunk, output ready);
endinterface

// ===== sv/vcsl_split.sv =====
// ----------------------------------------------------------------------------
// vcsl_split: volume bounds check and chunk address split
// Flags coordinates outside the volume and splits the rest into per-axis
// chunk indices and a z-major linear offset inside the chunk.
// ----------------------------------------------------------------------------
module vcsl_split
	import vcsl_pkg::*;
(
	input  logic signed [COORD_W-1:0] coord_z,
	input  logic signed [COORD_W-1:0] coord_y,
	input  logic signed [COORD_W-1:0] coord_x,
	input  cfg_t                      cfg,
	output split_t                    split
);

	logic [SHIFT_W-1:0] sz, sy, sx;
	logic [DIM_W-1:0]   uz, uy, ux;
	logic [7:0]         mz, my, mx;
	logic [OFFSET_W-1:0] part_z, part_y, part_x;
	logic [SHIFT_W:0]   shift_yx;

	// Saturate chunk shifts
	assign sz = (cfg.chunk_shift_z > MAX_SHIFT) ? MAX_SHIFT : cfg.chunk_shift_z;
	assign sy = (cfg.chunk_shift_y > MAX_SHIFT) ? MAX_SHIFT : cfg.chunk_shift_y;
	assign sx = (cfg.chunk_shift_x > MAX_SHIFT) ? MAX_SHIFT : cfg.chunk_shift_x;

	assign uz = coord_z[DIM_W-1:0];
	assign uy = coord_y[DIM_W-1:0];
	assign ux = coord_x[DIM_W-1:0];

	// Bounds: negative or not below the volume size on any axis
	assign split.out_of_range = coord_z[COORD_W-1] | coord_y[COORD_W-1] |
		coord_x[COORD_W-1] | (uz >= cfg.volume_depth) |
		(uy >= cfg.volume_height) | (ux >= cfg.volume_width);

	// Chunk indices
	assign split.chunk_z = uz >> sz;
	assign split.chunk_y = uy >> sy;
	assign split.chunk_x = ux >> sx;

	// Low-bit masks, at most eight bits per axis
	assign mz = 8'((9'd1 << sz) - 9'd1);
	assign my = 8'((9'd1 << sy) - 9'd1);
	assign mx = 8'((9'd1 << sx) - 9'd1);

	// Pack the in-chunk offset, z-major
	assign shift_yx = {1'b0, sy} + {1'b0, sx};
	assign part_z   = OFFSET_W'(uz[7:0] & mz) << shift_yx;
	assign part_y   = OFFSET_W'(uy[7:0] & my) << sx;
	assign part_x   = OFFSET_W'(ux[7:0] & mx);
	assign split.offset = part_z | part_y | part_x;

endmodule

// ===== sv/vcsl_slot_tags.sv =====
// ----------------------------------------------------------------------------
// vcsl_slot_tags: fully associative slot tag store
// Parallel compare of one key against every valid slot; on update, mark the
// hit slot most recent or replace the slot after the most recent one.
// ----------------------------------------------------------------------------
module vcsl_slot_tags
	import vcsl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [KEY_W-1:0] key,
	input  logic             update,
	output lookup_t          lookup
);

	logic [KEY_W-1:0]     slot_tag_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] slot_valid_q;
	logic [SLOT_BITS-1:0] recent_q;
	logic [SLOT_COUNT-1:0] match;
	logic [SLOT_BITS-1:0] hit_slot;
	logic [SLOT_BITS-1:0] victim;

	// Compare against every slot
	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			match[i] = slot_valid_q[i] && (slot_tag_q[i] == key);
		end
	end

	// Lowest matching slot wins
	always_comb begin
		hit_slot = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_slot = SLOT_BITS'(i);
			end
		end
	end

	// Round robin after the most recent slot
	assign victim = (recent_q == SLOT_BITS'(SLOT_COUNT - 1)) ? '0 :
		recent_q + SLOT_BITS'(1);

	assign lookup.hit  = |match;
	assign lookup.slot = lookup.hit ? hit_slot : victim;

	// Track recent slot and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q     <= '0;
			slot_valid_q <= '0;
		end else if (update) begin
			recent_q <= lookup.slot;
			if (!lookup.hit) begin
				slot_valid_q[victim] <= 1'b1;
			end
		end
	end

	// Write the key into the replaced slot
	always_ff @(posedge clk) begin
		if (update && !lookup.hit) begin
			slot_tag_q[victim] <= key;
		end
	end

`ifndef SYNTHESIS
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("more than one slot holds the same key");

	a_recent_follows: assert property (@(posedge clk) disable iff (!arst_n)
		update |=> recent_q == $past(lookup.slot))
		else $error("recent slot not updated to the looked-up slot");

	a_miss_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(update && !lookup.hit) |=> slot_valid_q[$past(victim)])
		else $error("replaced slot not marked valid");

	a_hit_keeps_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(update && lookup.hit) |=> slot_valid_q == $past(slot_valid_q))
		else $error("valid bits changed on a hit");
`endif

endmodule

// ===== sv/voxel_chunk_slot_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// voxel_chunk_slot_lookup_unit: voxel coordinate to chunk slot lookup
// Bounds check, chunk split and 16-way associative slot lookup with
// round-robin-after-most-recent replacement.
//
//   channel   dir  payload                                        beat on
//   coord     in   coord_z, coord_y, coord_x                      valid & ready
//   result    out  out_of_range, hit, slot_index, fetch_chunk_*,  valid & ready
//                  offset_in_chunk
//   cfg       in   cfg_index, cfg_data                            cfg_we
//
// One beat per cycle sustained while result.ready is high; a coord beat
// passes through an input register, then the split and tag compare into the
// result register. Slot state updates as an in-range item enters the result
// register, so the next item sees it. A stalled result holds both stages;
// coord.ready drops only when both are full. Reset clears valid bits and
// recent slot and loads the configuration defaults at once; no clearing pass.
// ----------------------------------------------------------------------------
module voxel_chunk_slot_lookup_unit
	import vcsl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	vcsl_coord_if.sink            coord,
	vcsl_result_if.source         result
);

	cfg_t   cfg_q;
	split_t split;
	lookup_t lookup;

	logic                      v_s1;
	logic signed [COORD_W-1:0] coord_z_s1, coord_y_s1, coord_x_s1;
	logic                      v_s2;
	logic                      advance;
	logic                      update;
	logic [KEY_W-1:0]          key;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volume_depth  <= '1;
			cfg_q.volume_height <= '1;
			cfg_q.volume_width  <= '1;
			cfg_q.chunk_shift_z <= SHIFT_W'(6);
			cfg_q.chunk_shift_y <= SHIFT_W'(6);
			cfg_q.chunk_shift_x <= SHIFT_W'(6);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VOLUME_DEPTH:  cfg_q.volume_depth  <= cfg_data[DIM_W-1:0];
				REG_VOLUME_HEIGHT: cfg_q.volume_height <= cfg_data[DIM_W-1:0];
				REG_VOLUME_WIDTH:  cfg_q.volume_width  <= cfg_data[DIM_W-1:0];
				REG_CHUNK_SHIFT_Z: cfg_q.chunk_shift_z <= cfg_data[SHIFT_W-1:0];
				REG_CHUNK_SHIFT_Y: cfg_q.chunk_shift_y <= cfg_data[SHIFT_W-1:0];
				REG_CHUNK_SHIFT_X: cfg_q.chunk_shift_x <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline handshake
	assign advance     = v_s1 && (!v_s2 || result.ready);
	assign coord.ready = !v_s1 || advance;
	assign update      = advance && !split.out_of_range;

	// Stage 1: capture the coordinate beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (coord.ready) begin
			v_s1 <= coord.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (coord.valid && coord.ready) begin
			coord_z_s1 <= coord.coord_z;
			coord_y_s1 <= coord.coord_y;
			coord_x_s1 <= coord.coord_x;
		end
	end

	vcsl_split u_split (
		.coord_z (coord_z_s1),
		.coord_y (coord_y_s1),
		.coord_x (coord_x_s1),
		.cfg     (cfg_q),
		.split   (split)
	);

	// Pack the chunk key, each index masked to the key field width
	assign key = {split.chunk_z[INDEX_BITS-1:0], split.chunk_y[INDEX_BITS-1:0],
		split.chunk_x[INDEX_BITS-1:0]};

	vcsl_slot_tags u_slot_tags (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key),
		.update (update),
		.lookup (lookup)
	);

	// Stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || result.ready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (split.out_of_range) begin
				result.out_of_range    <= 1'b1;
				result.hit             <= 1'b0;
				result.slot_index      <= '0;
				result.fetch_chunk_z   <= '0;
				result.fetch_chunk_y   <= '0;
				result.fetch_chunk_x   <= '0;
				result.offset_in_chunk <= '0;
			end else begin
				result.out_of_range    <= 1'b0;
				result.hit             <= lookup.hit;
				result.slot_index      <= lookup.slot;
				result.fetch_chunk_z   <= lookup.hit ? '0 : split.chunk_z;
				result.fetch_chunk_y   <= lookup.hit ? '0 : split.chunk_y;
				result.fetch_chunk_x   <= lookup.hit ? '0 : split.chunk_x;
				result.offset_in_chunk <= split.offset;
			end
		end
	end

	assign result.valid = v_s2;

endmodule
